// ===== rtl/core/krt_pkg.sv =====
// Shared widths, command codes and status codes of the keyed record table.
`timescale 1ns / 1ps

package krt_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned SLOT_W  = 6;

  // Slave word: opcode, part_key, amount, padded to whole bytes.
  localparam int unsigned S_TDATA_W = 72;
  // Master word: status, slot, quantity.
  localparam int unsigned M_TDATA_W = 40;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EXISTS    = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

endpackage

// ===== rtl/core/krt_mem.sv =====
// Key and quantity stores: one synchronous read port, one write port.
`timescale 1ns / 1ps

module krt_mem #(
  parameter int unsigned DEPTH = krt_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk_i,
  input  logic                             rd_en_i,
  input  logic [AW-1:0]                    rd_addr_i,
  output logic signed [krt_pkg::KEY_W-1:0] rd_key_o,
  output logic signed [krt_pkg::QTY_W-1:0] rd_qty_o,
  input  logic                             we_key_i,
  input  logic                             we_qty_i,
  input  logic [AW-1:0]                    wr_addr_i,
  input  logic signed [krt_pkg::KEY_W-1:0] wr_key_i,
  input  logic signed [krt_pkg::QTY_W-1:0] wr_qty_i
);

  logic signed [krt_pkg::KEY_W-1:0] key_mem [DEPTH];
  logic signed [krt_pkg::QTY_W-1:0] qty_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_key_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    if (we_qty_i) begin
      qty_mem[wr_addr_i] <= wr_qty_i;
    end
  end

  // Registered read: data appears the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o <= key_mem[rd_addr_i];
      rd_qty_o <= qty_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/core/keyed_record_table_core.sv =====
// Top level of the keyed record table: command sequencer, linear key scan, result register.
`timescale 1ns / 1ps

// Usage
//   Slave channel s_axis_* takes one command word: insert, search or update
//   of a signed 32-bit key. Master channel m_axis_* returns exactly one result
//   word per command: status, slot and quantity after the operation.
//   Records live in a synchronous key/quantity store of CAPACITY entries,
//   filled in order from slot 0; lookup scans the filled slots upward and the
//   first match wins.
// Throughput
//   The scan reads one stored key per cycle from the single read port and
//   visits at most the filled slots, stopping at the first match; the
//   command then loads the result register and returns to idle, and only
//   in idle is the next word taken. Opcode 3 skips the scan.
// Reset
//   Reset empties the table (fill count zero) and drops any pending result;
//   the stores need no clearing pass since only filled slots are read.
// Stall
//   A result waiting on m_axis_tready_i does not stop the next command from
//   being taken; the sequencer holds its own result until the register frees.

module keyed_record_table_core #(
  parameter int unsigned CAPACITY = krt_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [1:0] opcode, [33:2] part_key, [65:34] amount, [71:66] zero
  input  logic [krt_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [1:0] status, [7:2] slot, [39:8] quantity
  output logic [krt_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [krt_pkg::OP_W-1:0]         op_q, op_d;
  logic signed [krt_pkg::KEY_W-1:0] key_q, key_d;
  logic signed [krt_pkg::QTY_W-1:0] amt_q, amt_d;
  logic [CW-1:0]                    idx_q, idx_d;
  logic [CW-1:0]                    count_q, count_d;
  logic                             cmp_v_q, cmp_v_d;
  logic [AW-1:0]                    cmp_idx_q, cmp_idx_d;

  logic [krt_pkg::ST_W-1:0]         res_st_q, res_st_d;
  logic [krt_pkg::SLOT_W-1:0]       res_slot_q, res_slot_d;
  logic signed [krt_pkg::QTY_W-1:0] res_qty_q, res_qty_d;

  logic                             m_valid_q, m_valid_d;
  logic [krt_pkg::ST_W-1:0]         m_st_q, m_st_d;
  logic [krt_pkg::SLOT_W-1:0]       m_slot_q, m_slot_d;
  logic signed [krt_pkg::QTY_W-1:0] m_qty_q, m_qty_d;

  logic                             rd_en;
  logic signed [krt_pkg::KEY_W-1:0] rd_key;
  logic signed [krt_pkg::QTY_W-1:0] rd_qty;
  logic                             we_key, we_qty;
  logic [AW-1:0]                    wr_addr;
  logic signed [krt_pkg::QTY_W-1:0] wr_qty;

  logic in_accept, hit, more, out_load;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign hit             = cmp_v_q && (rd_key == key_q);
  assign more            = (idx_q < count_q);
  assign out_load        = (state_q == S_OUT) && (!m_valid_q || m_axis_tready_i);

  krt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_key_o  (rd_key),
    .rd_qty_o  (rd_qty),
    .we_key_i  (we_key),
    .we_qty_i  (we_qty),
    .wr_addr_i (wr_addr),
    .wr_key_i  (key_q),
    .wr_qty_i  (wr_qty)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    amt_d      = amt_q;
    idx_d      = idx_q;
    count_d    = count_q;
    cmp_v_d    = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;
    res_qty_d  = res_qty_q;
    rd_en      = 1'b0;
    we_key     = 1'b0;
    we_qty     = 1'b0;
    wr_addr    = count_q[AW-1:0];
    wr_qty     = amt_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          op_d  = s_axis_tdata_i[1:0];
          key_d = s_axis_tdata_i[33:2];
          amt_d = s_axis_tdata_i[65:34];
          idx_d = '0;
          if (s_axis_tdata_i[1:0] == krt_pkg::OP_INSERT ||
              s_axis_tdata_i[1:0] == krt_pkg::OP_SEARCH ||
              s_axis_tdata_i[1:0] == krt_pkg::OP_UPDATE) begin
            state_d = S_SCAN;
          end else begin
            res_st_d   = krt_pkg::ST_NOT_FOUND;
            res_slot_d = '0;
            res_qty_d  = '0;
            state_d    = S_OUT;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          state_d = S_OUT;
          case (op_q)
            krt_pkg::OP_INSERT: begin
              res_st_d   = krt_pkg::ST_EXISTS;
              res_slot_d = '0;
              res_qty_d  = '0;
            end
            krt_pkg::OP_UPDATE: begin
              // Read-modify-write of the matched quantity; the sum wraps.
              wr_addr    = cmp_idx_q;
              wr_qty     = rd_qty + amt_q;
              we_qty     = 1'b1;
              res_st_d   = krt_pkg::ST_OK;
              res_slot_d = krt_pkg::SLOT_W'(cmp_idx_q);
              res_qty_d  = rd_qty + amt_q;
            end
            default: begin
              res_st_d   = krt_pkg::ST_OK;
              res_slot_d = krt_pkg::SLOT_W'(cmp_idx_q);
              res_qty_d  = rd_qty;
            end
          endcase
        end else if (more) begin
          // Issue the next read; its key is compared next cycle.
          rd_en     = 1'b1;
          cmp_v_d   = 1'b1;
          cmp_idx_d = idx_q[AW-1:0];
          idx_d     = idx_q + 1'b1;
        end else begin
          state_d    = S_OUT;
          res_slot_d = '0;
          res_qty_d  = '0;
          if (op_q == krt_pkg::OP_INSERT) begin
            if (count_q == CAP_CNT) begin
              res_st_d = krt_pkg::ST_FULL;
            end else begin
              we_key     = 1'b1;
              we_qty     = 1'b1;
              count_d    = count_q + 1'b1;
              res_st_d   = krt_pkg::ST_OK;
              res_slot_d = krt_pkg::SLOT_W'(count_q[AW-1:0]);
              res_qty_d  = amt_q;
            end
          end else begin
            res_st_d = krt_pkg::ST_NOT_FOUND;
          end
        end
      end

      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_st_d   = m_st_q;
    m_slot_d = m_slot_q;
    m_qty_d  = m_qty_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_st_d    = res_st_q;
      m_slot_d  = res_slot_q;
      m_qty_d   = res_qty_q;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      cmp_v_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      cmp_v_q    <= cmp_v_d;
      m_valid_q  <= m_valid_d;
      op_q       <= op_d;
      key_q      <= key_d;
      amt_q      <= amt_d;
      idx_q      <= idx_d;
      cmp_idx_q  <= cmp_idx_d;
      res_st_q   <= res_st_d;
      res_slot_q <= res_slot_d;
      res_qty_q  <= res_qty_d;
      m_st_q     <= m_st_d;
      m_slot_q   <= m_slot_d;
      m_qty_q    <= m_qty_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_qty_q, m_slot_q, m_st_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CAP_CNT)
    else $error("fill count exceeds capacity");

  a_count_grows_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_key |=> (count_q == $past(count_q) + 1'b1))
    else $error("key write without fill count advance");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !we_key |=> $stable(count_q))
    else $error("fill count moved without an insert");

  a_fail_zeroed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_st_q != krt_pkg::ST_OK) |-> (m_slot_q == '0 && m_qty_q == '0))
    else $error("failed result carries non-zero slot or quantity");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we_key || we_qty) |-> (state_q == S_SCAN && !rd_en))
    else $error("store write outside the scan finish");

endmodule

// ===== bench/tb_keyed_record_table_core.sv =====
// Self-checking bench for the keyed record table: insert, search and update over a stream port.
`timescale 1ns / 1ps

module tb_keyed_record_table_core;

  localparam int unsigned TABLE_DEPTH = krt_pkg::CAPACITY_DEF;
  localparam int unsigned RANDOM_CMDS = 1400;
  localparam int unsigned KEY_POOL_SIZE = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam logic [krt_pkg::OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [krt_pkg::ST_W-1:0]   status;
    logic [krt_pkg::SLOT_W-1:0] slot;
    logic [krt_pkg::QTY_W-1:0]  quantity;
  } record_result_t;

  typedef struct {
    logic [krt_pkg::OP_W-1:0]  opcode;
    logic [krt_pkg::KEY_W-1:0] part_key;
    logic [krt_pkg::QTY_W-1:0] amount;
    bit                        fixed;
    record_result_t            fixed_result;
  } table_cmd_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  // [1:0] opcode, [33:2] part_key, [65:34] amount, [71:66] zero
  logic [krt_pkg::S_TDATA_W-1:0] s_axis_tdata_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  // [1:0] status, [7:2] slot, [39:8] quantity
  logic [krt_pkg::M_TDATA_W-1:0] m_axis_tdata_o;

  keyed_record_table_core #(
    .CAPACITY(TABLE_DEPTH)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Shadow copy of the table
  logic [krt_pkg::KEY_W-1:0] shadow_keys [TABLE_DEPTH];
  logic [krt_pkg::QTY_W-1:0] shadow_qty  [TABLE_DEPTH];
  int unsigned               shadow_fill;

  record_result_t            pending_results [$];
  table_cmd_t                cmd_list [$];
  table_cmd_t                cur_cmd;
  logic [krt_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];
  int unsigned               error_count;
  int unsigned               cycle_count;
  bit                        stimulus_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic record_result_t make_result(logic [krt_pkg::ST_W-1:0] st,
                                                 logic [krt_pkg::SLOT_W-1:0] sl,
                                                 logic [krt_pkg::QTY_W-1:0] q);
    record_result_t r;
    r.status   = st;
    r.slot     = sl;
    r.quantity = q;
    return r;
  endfunction

  function automatic table_cmd_t make_cmd(logic [krt_pkg::OP_W-1:0] op,
                                          logic [krt_pkg::KEY_W-1:0] k,
                                          logic [krt_pkg::QTY_W-1:0] a, bit fx,
                                          record_result_t r);
    table_cmd_t c;
    c.opcode       = op;
    c.part_key     = k;
    c.amount       = a;
    c.fixed        = fx;
    c.fixed_result = r;
    return c;
  endfunction

  // Apply one command to the shadow table and return the result it should give
  function automatic record_result_t apply_table_cmd(logic [krt_pkg::OP_W-1:0] op,
                                                     logic [krt_pkg::KEY_W-1:0] k,
                                                     logic [krt_pkg::QTY_W-1:0] a);
    int unsigned idx;
    bit          hit;
    idx = 0;
    hit = 1'b0;
    if (op == OP_SPARE) return make_result(krt_pkg::ST_NOT_FOUND, '0, '0);
    for (int unsigned i = 0; i < shadow_fill; i++) begin
      if (!hit && shadow_keys[i] == k) begin
        hit = 1'b1;
        idx = i;
      end
    end
    if (op == krt_pkg::OP_INSERT) begin
      if (hit) return make_result(krt_pkg::ST_EXISTS, '0, '0);
      if (shadow_fill >= TABLE_DEPTH) return make_result(krt_pkg::ST_FULL, '0, '0);
      shadow_keys[shadow_fill] = k;
      shadow_qty[shadow_fill]  = a;
      shadow_fill++;
      return make_result(krt_pkg::ST_OK, krt_pkg::SLOT_W'(shadow_fill - 1), a);
    end
    if (!hit) return make_result(krt_pkg::ST_NOT_FOUND, '0, '0);
    if (op == krt_pkg::OP_UPDATE) shadow_qty[idx] = shadow_qty[idx] + a;
    return make_result(krt_pkg::ST_OK, krt_pkg::SLOT_W'(idx), shadow_qty[idx]);
  endfunction

  function automatic logic [krt_pkg::QTY_W-1:0] pick_amount();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom;
    if (r < 85) return krt_pkg::QTY_W'($signed($urandom_range(0, 32)) - 16);
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      default: return '0;
    endcase
  endfunction

  task automatic build_commands();
    record_result_t none;
    logic [krt_pkg::OP_W-1:0] op;
    logic [krt_pkg::KEY_W-1:0] k;
    int unsigned r;
    none = make_result('0, '0, '0);
    // Directed part: empty table, extremes, wrap-around, duplicate insert, spare opcode
    cmd_list.push_back(make_cmd(krt_pkg::OP_SEARCH, 32'h0, 32'h0, 1,
                                make_result(krt_pkg::ST_NOT_FOUND, '0, '0)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
                                make_result(krt_pkg::ST_NOT_FOUND, '0, '0)));
    cmd_list.push_back(make_cmd(OP_SPARE, 32'h0, 32'h0, 1,
                                make_result(krt_pkg::ST_NOT_FOUND, '0, '0)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                make_result(krt_pkg::ST_OK, 6'd0, 32'h7FFF_FFFF)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000, 1,
                                make_result(krt_pkg::ST_OK, 6'd1, 32'h8000_0000)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_INSERT, 32'h8000_0000, 32'h5, 1,
                                make_result(krt_pkg::ST_EXISTS, '0, '0)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_UPDATE, 32'h8000_0000, 32'h1, 1,
                                make_result(krt_pkg::ST_OK, 6'd0, 32'h8000_0000)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_UPDATE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1,
                                make_result(krt_pkg::ST_OK, 6'd1, 32'h7FFF_FFFF)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_SEARCH, 32'h0, 32'hFFFF_FFFF, 1,
                                make_result(krt_pkg::ST_NOT_FOUND, '0, '0)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_INSERT, 32'h0, 32'h0, 1,
                                make_result(krt_pkg::ST_OK, 6'd2, 32'h0)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                make_result(krt_pkg::ST_OK, 6'd3, 32'hFFFF_FFFF)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_SEARCH, 32'hFFFF_FFFF, 32'h1234_5678, 1,
                                make_result(krt_pkg::ST_OK, 6'd3, 32'hFFFF_FFFF)));
    cmd_list.push_back(make_cmd(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                make_result(krt_pkg::ST_NOT_FOUND, '0, '0)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_UPDATE, 32'h0, 32'h8000_0000, 1,
                                make_result(krt_pkg::ST_OK, 6'd2, 32'h8000_0000)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_UPDATE, 32'h0, 32'h8000_0000, 1,
                                make_result(krt_pkg::ST_OK, 6'd2, 32'h0)));
    cmd_list.push_back(make_cmd(krt_pkg::OP_SEARCH, 32'h8000_0000, 32'h0, 0, none));
    cmd_list.push_back(make_cmd(krt_pkg::OP_INSERT, $urandom, $urandom, 0, none));
    cmd_list.push_back(make_cmd(krt_pkg::OP_UPDATE, 32'h7FFF_FFFF, $urandom, 0, none));
    cmd_list.push_back(make_cmd(krt_pkg::OP_SEARCH, 32'h7FFF_FFFF, 32'h0, 0, none));

    // Pool larger than the table, so the table fills and misses keep happening
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7FFF_FFFF;
    for (int unsigned i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    for (int unsigned n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35)      op = krt_pkg::OP_INSERT;
      else if (r < 65) op = krt_pkg::OP_SEARCH;
      else if (r < 95) op = krt_pkg::OP_UPDATE;
      else             op = OP_SPARE;
      if ($urandom_range(0, 99) < 85) k = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
      else                            k = $urandom;
      cmd_list.push_back(make_cmd(op, k, pick_amount(), 0, none));
    end
  endtask

  // Sender: bursts of words separated by random gaps
  initial begin : sender
    int unsigned burst_left;
    int unsigned gap;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    stimulus_done   = 1'b0;
    burst_left      = 0;
    build_commands();
    cur_cmd = cmd_list[0];
    @(posedge rst_ni);
    @(negedge clk_i);
    foreach (cmd_list[n]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
        if (gap != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      end
      cur_cmd = cmd_list[n];
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= {6'b0, cmd_list[n].amount, cmd_list[n].part_key, cmd_list[n].opcode};
      @(posedge clk_i);
      while (!s_axis_tready_o) @(posedge clk_i);
      @(negedge clk_i);
      burst_left--;
    end
    s_axis_tvalid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: switch between randomly chosen stall patterns, each held over a random span
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    m_axis_tready_i = 1'b0;
    mode = 0;
    span = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(20, 150);
      end
      span--;
      case (mode)
        0: m_axis_tready_i <= 1'b1;
        1: m_axis_tready_i <= $urandom_range(0, 1);
        2: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
        default: m_axis_tready_i <= ~m_axis_tready_i;
      endcase
    end
  end

  // Predict on each accepted command word, check each accepted result word
  always @(posedge clk_i) begin : scoreboard
    record_result_t predicted;
    record_result_t want;
    record_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predicted = apply_table_cmd(s_axis_tdata_i[1:0], s_axis_tdata_i[33:2],
                                    s_axis_tdata_i[65:34]);
        pending_results.push_back(cur_cmd.fixed ? cur_cmd.fixed_result : predicted);
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = make_result(m_axis_tdata_o[1:0], m_axis_tdata_o[7:2], m_axis_tdata_o[39:8]);
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected: status %0d slot %0d qty %0d",
                   $time, got.status, got.slot, $signed(got.quantity));
          error_count++;
        end else begin
          want = pending_results.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, got.status);
            error_count++;
          end
          if (got.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, got %0d", $time, want.slot, got.slot);
            error_count++;
          end
          if (got.quantity !== want.quantity) begin
            $display("%0t: quantity mismatch: expected %0d, got %0d",
                     $time, $signed(want.quantity), $signed(got.quantity));
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    wait (stimulus_done);
    while (pending_results.size() != 0) @(posedge clk_i);
    // Drain: let any stray word show up
    repeat (TABLE_DEPTH + 8) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== keyed_record_table_core.f =====
rtl/core/krt_pkg.sv
rtl/core/krt_mem.sv
rtl/core/keyed_record_table_core.sv
bench/tb_keyed_record_table_core.sv
